>>> src/dsha_pkg.sv
// Package for the double SHA-512 proof-of-work checker.
// Holds payload structs, round constants and the SHA-512 helper functions.
// No dependencies.
`default_nettype none
package dsha_pkg;

   localparam int unsigned WordWidth  = 64;
   localparam int unsigned NumRounds  = 80;
   localparam int unsigned HashWords  = 8;
   localparam int unsigned BlockWords = 16;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_TRIAL = 1'b1;

   typedef logic [WordWidth-1:0] word_type;
   typedef word_type [HashWords-1:0] state_type;
   typedef word_type [BlockWords-1:0] block_type;

   typedef struct packed {
      logic     op;
      logic [2:0] word_index;
      word_type value;
   } req_type;

   typedef struct packed {
      logic     found;
      word_type nonce_out;
      word_type trial_value;
   } rsp_type;

   localparam state_type StartIv = '{
      64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b, 64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
      64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b, 64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
   };

   function automatic word_type round_k(input logic [6:0] t);
      word_type k;
      begin
         case (t)
            7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
         endcase
         return k;
      end
   endfunction

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (WordWidth - n));
   endfunction

   // One round of the compression function on the working state.
   function automatic state_type sha_round(input state_type v, input word_type kw);
      word_type t1, t2, big0, big1, ch, maj;
      state_type r;
      begin
         big1 = rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41);
         ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
         t1   = v[7] + big1 + ch + kw;
         big0 = rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39);
         maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
         t2   = big0 + maj;
         r[7] = v[6];
         r[6] = v[5];
         r[5] = v[4];
         r[4] = v[3] + t1;
         r[3] = v[2];
         r[2] = v[1];
         r[1] = v[0];
         r[0] = t1 + t2;
         return r;
      end
   endfunction

   // Message schedule: drops w[t-16] and appends w[t].
   function automatic block_type sched_step(input block_type w);
      word_type s0, s1;
      block_type r;
      begin
         s0 = rotr(w[1], 1) ^ rotr(w[1], 8) ^ (w[1] >> 7);
         s1 = rotr(w[14], 19) ^ rotr(w[14], 61) ^ (w[14] >> 6);
         for (int i = 0; i < BlockWords - 1; i++) begin
            r[i] = w[i+1];
         end
         r[BlockWords-1] = w[0] + s0 + w[9] + s1;
         return r;
      end
   endfunction

endpackage
`default_nettype wire

>>> src/dsha_compress.sv
// One SHA-512 compression from the IV, one round per pipeline stage.
// Depends on dsha_pkg. Stalls hold every stage; a tag rides along.
`default_nettype none
module dsha_compress #(
   parameter int unsigned TagWidth = 64
) (
   input  wire  logic                  clock,
   input  wire  logic                  reset,
   input  wire  logic                  advance,
   input  wire  logic                  in_valid,
   input  wire  dsha_pkg::block_type   in_block,
   input  wire  logic [TagWidth-1:0]   in_tag,
   output logic                        out_valid,
   output dsha_pkg::state_type         out_digest,
   output logic [TagWidth-1:0]         out_tag
);

   localparam int unsigned Rounds = dsha_pkg::NumRounds;

   logic                  valid_ff [Rounds+1];
   dsha_pkg::state_type   state_ff [Rounds+1];
   dsha_pkg::block_type   sched_ff [Rounds+1];
   logic [TagWidth-1:0]   tag_ff   [Rounds+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
      if (advance) begin
         state_ff[0] <= dsha_pkg::StartIv;
         sched_ff[0] <= in_block;
         tag_ff[0]   <= in_tag;
      end
   end

   for (genvar g = 0; g < Rounds; g++) begin : g_round
      dsha_pkg::state_type state_in;
      dsha_pkg::block_type sched_in;
      // Round constant and schedule word are added before the round.
      assign state_in = dsha_pkg::sha_round(state_ff[g],
         dsha_pkg::round_k(7'(g)) + sched_ff[g][0]);
      assign sched_in = dsha_pkg::sched_step(sched_ff[g]);
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[g+1] <= valid_ff[g];
         end
         if (advance) begin
            state_ff[g+1] <= state_in;
            sched_ff[g+1] <= sched_in;
            tag_ff[g+1]   <= tag_ff[g];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < dsha_pkg::HashWords; i++) begin
         out_digest[i] = state_ff[Rounds][i] + dsha_pkg::StartIv[i];
      end
   end
   assign out_valid = valid_ff[Rounds];
   assign out_tag   = tag_ff[Rounds];

endmodule
`default_nettype wire

>>> src/double_sha512_pow_check_top.sv
// Top level of the double SHA-512 proof-of-work checker.
// Depends on dsha_pkg and dsha_compress (two instances, one per hash).
//
//  channel  direction  handshake          payload
//  req_     in         req_valid/req_stall  dsha_pkg::req_type
//  rsp_     out        rsp_valid/rsp_stall  dsha_pkg::rsp_type
//  csr_     in         csr_valid/csr_ready  64-bit target
//
// One trial enters every cycle unless a waiting result is stalled. Each of the
// two compression pipelines has an input register and 80 round stages (81
// registers), and the output register adds one more. The digest add and the
// compare are combinational in front of the register that takes them.
// Reset is synchronous and clears all valid bits and the target; the stored
// initial hash words are not cleared. A stall on rsp_ freezes the whole
// pipeline; an empty output register lets it run.
`default_nettype none
module double_sha512_pow_check_top (
   input  wire  logic                clock,
   input  wire  logic                reset,
   input  wire  logic                req_valid,
   output logic                      req_stall,
   input  wire  dsha_pkg::req_type   req_data,
   output logic                      rsp_valid,
   input  wire  logic                rsp_stall,
   output dsha_pkg::rsp_type         rsp_data,
   input  wire  logic                csr_valid,
   output logic                      csr_ready,
   input  wire  dsha_pkg::word_type  csr_data
);

   // The tag that rides through both pipelines is the nonce.
   localparam int unsigned TagWidth = dsha_pkg::WordWidth;

   dsha_pkg::word_type target_ff;
   dsha_pkg::word_type init_ff [dsha_pkg::HashWords];

   logic                advance;
   logic                req_accept;
   dsha_pkg::block_type first_block;
   dsha_pkg::block_type second_block;
   logic                mid_valid;
   dsha_pkg::state_type mid_digest;
   logic [TagWidth-1:0] mid_tag;
   logic                fin_valid;
   dsha_pkg::state_type fin_digest;
   logic [TagWidth-1:0] fin_tag;

   logic                out_valid_ff;
   dsha_pkg::rsp_type   out_data_ff;

   // The pipeline moves whenever the output register is free or being taken.
   assign advance    = !out_valid_ff || !rsp_stall;
   assign req_stall  = !advance;
   assign req_accept = req_valid && advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_valid) begin
         target_ff <= csr_data;
      end
   end

   // Loads write the initial hash store and produce no transaction.
   always_ff @(posedge clock) begin
      if (req_accept && req_data.op == dsha_pkg::OP_LOAD) begin
         init_ff[req_data.word_index] <= req_data.value;
      end
   end

   // First block: nonce, initial hash, padding, 576-bit length.
   always_comb begin
      first_block    = '0;
      first_block[0] = req_data.value;
      for (int i = 0; i < dsha_pkg::HashWords; i++) begin
         first_block[i+1] = init_ff[i];
      end
      first_block[9]  = 64'h8000000000000000;
      first_block[15] = 64'd576;
   end

   dsha_compress #(.TagWidth(TagWidth)) u_first (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_accept && req_data.op == dsha_pkg::OP_TRIAL),
      .in_block   (first_block),
      .in_tag     (req_data.value),
      .out_valid  (mid_valid),
      .out_digest (mid_digest),
      .out_tag    (mid_tag)
   );

   // Second block: first digest, padding, 512-bit length.
   always_comb begin
      second_block = '0;
      for (int i = 0; i < dsha_pkg::HashWords; i++) begin
         second_block[i] = mid_digest[i];
      end
      second_block[8]  = 64'h8000000000000000;
      second_block[15] = 64'd512;
   end

   dsha_compress #(.TagWidth(TagWidth)) u_second (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (mid_valid),
      .in_block   (second_block),
      .in_tag     (mid_tag),
      .out_valid  (fin_valid),
      .out_digest (fin_digest),
      .out_tag    (fin_tag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= fin_valid;
      end
      if (advance) begin
         out_data_ff.found       <= fin_digest[0] < target_ff;
         out_data_ff.nonce_out   <= fin_tag;
         out_data_ff.trial_value <= fin_digest[0];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // A stalled result must stay put until it is taken.
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");

   // The input side is stalled exactly when a result waits.
   a_stall : assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output");

   // The found flag agrees with the reported value and target.
   a_found : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(csr_valid) && !$past(reset) |->
         rsp_data.found == (rsp_data.trial_value < $past(target_ff)) ||
         $past(rsp_valid && rsp_stall))
      else $error("found flag mismatch");

endmodule
`default_nettype wire
